FILE: design/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

    // Screen geometry defaults
    localparam int SCREEN_COLS_DEF = 80;
    localparam int SCREEN_ROWS_DEF = 25;

    // Fixed field widths
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int ADDR_W   = 11;
    localparam int DATA_W   = 16;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int CNT_W    = 18;

    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0C;
    localparam logic [CNT_W-1:0]  COUNT_TOP  = 18'd131072;

    // Front-to-back queue depth
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        CLS_PRINT,
        CLS_CR,
        CLS_LF
    } t_cls;

    typedef struct packed {
        t_cls              cls;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_cmd;

endpackage

`default_nettype wire

FILE: design/tcw_in_if.sv
`default_nettype none

interface tcw_in_if
    import tcw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_byte;
    logic              last_char;

    modport source (output valid, output char_byte, output last_char, input ready);
    modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

`default_nettype wire

FILE: design/tcw_out_if.sv
`default_nettype none

interface tcw_out_if
    import tcw_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 cell_write;
    logic [ADDR_W-1:0]    cell_address;
    logic [DATA_W-1:0]    cell_data;
    logic                 scroll_up;
    logic [ROW_OUT_W-1:0] cursor_row_out;
    logic [COL_OUT_W-1:0] cursor_col_out;
    logic [CNT_W-1:0]     chars_done;

    modport source (
        output valid, output cell_write, output cell_address, output cell_data,
        output scroll_up, output cursor_row_out, output cursor_col_out,
        output chars_done, input ready
    );
    modport sink (
        input valid, input cell_write, input cell_address, input cell_data,
        input scroll_up, input cursor_row_out, input cursor_col_out,
        input chars_done, output ready
    );
endinterface

`default_nettype wire

FILE: design/tcw_front.sv
`default_nettype none

// Accepts characters, classifies them and queues commands for the back end.
module tcw_front
    import tcw_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    tcw_in_if.sink      i_in,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  wire         i_cmd_pop
);

    t_cmd                r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;

    t_cmd cls_cmd;
    logic push;
    logic pop;

    always_comb begin
        cls_cmd.ch   = i_in.char_byte;
        cls_cmd.last = i_in.last_char;
        priority if (i_in.char_byte == CH_CR) begin
            cls_cmd.cls = CLS_CR;
        end else if (i_in.char_byte == CH_LF) begin
            cls_cmd.cls = CLS_LF;
        end else begin
            cls_cmd.cls = CLS_PRINT;
        end
    end

    assign i_in.ready  = (r_count != Q_CNT_W'(Q_DEPTH));
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls_cmd;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count above depth");
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == Q_CNT_W'(Q_DEPTH)) && !pop |=> r_count == Q_CNT_W'(Q_DEPTH))
        else $error("full queue lost an entry without a pop");
    a_empty_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) && !i_in.valid |=> r_count == '0)
        else $error("queue filled without an input item");
`endif

endmodule

`default_nettype wire

FILE: design/tcw_back.sv
`default_nettype none

// Cursor state, cell address/data and request count; registered result.
module tcw_back
    import tcw_pkg::*;
#(
    parameter int SCREEN_COLS = SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cmd_valid,
    input  wire t_cmd         i_cmd,
    output logic              o_cmd_pop,
    input  wire [ATTR_W-1:0]  i_attr,
    tcw_out_if.source         o_res
);

    localparam int COL_W  = $clog2(SCREEN_COLS);
    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int FULL_W = $clog2(SCREEN_COLS * SCREEN_ROWS);

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic             r_out_valid;
    logic             r_out_wr, n_out_wr;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;
    logic [DATA_W-1:0] r_out_data, n_out_data;
    logic             r_out_scroll, n_out_scroll;
    logic [CNT_W-1:0] r_out_cnt, n_out_cnt;

    logic [FULL_W-1:0] addr_full;
    logic              at_last_row;
    logic              at_last_col;

    assign o_cmd_pop   = i_cmd_valid && (!r_out_valid || o_res.ready);
    assign addr_full   = FULL_W'(r_row) * FULL_W'(SCREEN_COLS) + FULL_W'(r_col);
    assign at_last_row = (r_row == ROW_W'(SCREEN_ROWS - 1));
    assign at_last_col = (r_col == COL_W'(SCREEN_COLS - 1));

    always_comb begin
        n_row        = r_row;
        n_col        = r_col;
        n_out_wr     = 1'b0;
        n_out_addr   = '0;
        n_out_data   = '0;
        n_out_scroll = 1'b0;
        unique case (i_cmd.cls)
            CLS_CR: begin
                n_col = '0;
            end
            CLS_LF: begin
                n_col = '0;
                if (at_last_row) begin
                    n_out_scroll = 1'b1;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            CLS_PRINT: begin
                n_out_wr   = 1'b1;
                n_out_addr = ADDR_W'(addr_full);
                n_out_data = {i_attr, i_cmd.ch};
                if (at_last_col) begin
                    n_col = '0;
                    if (at_last_row) begin
                        n_out_scroll = 1'b1;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            default: begin
                n_row = r_row;
            end
        endcase
        // Saturating count; the item reports its own count, then clears on last
        n_out_cnt = (r_cnt == COUNT_TOP) ? r_cnt : r_cnt + 1'b1;
        n_cnt     = i_cmd.last ? '0 : n_out_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_row       <= n_row;
                r_col       <= n_col;
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_out_wr     <= n_out_wr;
            r_out_addr   <= n_out_addr;
            r_out_data   <= n_out_data;
            r_out_scroll <= n_out_scroll;
            r_out_cnt    <= n_out_cnt;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.cell_write     = r_out_wr;
    assign o_res.cell_address   = r_out_addr;
    assign o_res.cell_data      = r_out_data;
    assign o_res.scroll_up      = r_out_scroll;
    assign o_res.cursor_row_out = ROW_OUT_W'(r_row);
    assign o_res.cursor_col_out = COL_OUT_W'(r_col);
    assign o_res.chars_done     = r_out_cnt;

`ifndef SYNTHESIS
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= ROW_W'(SCREEN_ROWS - 1))
        else $error("cursor row off screen");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_W'(SCREEN_COLS - 1))
        else $error("cursor column off screen");
    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_scroll |-> at_last_row && (r_col == '0))
        else $error("scroll request without cursor at start of bottom row");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= COUNT_TOP)
        else $error("request count above saturation");
`endif

endmodule

`default_nettype wire

FILE: design/text_console_writer.sv
// Channel  Dir  Handshake      Payload
// i_in     in   valid/ready    char_byte[7:0], last_char
// o_res    out  valid/ready    cell_write, cell_address[10:0], cell_data[15:0],
//                              scroll_up, cursor_row_out[4:0], cursor_col_out[6:0],
//                              chars_done[17:0]
// cfg      in   i_cfg_we       i_cfg_wdata[7:0] -> text attribute
//
// One item per cycle sustained while the output is not stalled; an accepted
// item passes through a queue slot and then the result register before its
// result can leave.
// The cursor update in the back end is the per-item loop; it closes through the cursor registers.
// Reset (synchronous, active low) homes the cursor, clears the count, empties
// the queue and loads attribute 0x0C.
// A stalled output keeps accepting until the two-entry queue fills.
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int SCREEN_COLS = SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    tcw_in_if.sink           i_in,
    tcw_out_if.source        o_res,
    input  wire              i_cfg_we,
    input  wire [ATTR_W-1:0] i_cfg_wdata
);

    // Attribute register; written only while the block is idle is the user's duty, the block does not enforce it.
    logic [ATTR_W-1:0] r_attr;

    // Front-to-back command path
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_wdata;
        end
    end

    // Front end: accept, classify CR / LF / printable, queue.
    tcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back end: cursor, cell write, count, result register.
    tcw_back #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_attr      (r_attr),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_text_console_writer.sv
`timescale 1ns / 100ps

module tb_text_console_writer;
    import tcw_pkg::*;

    // One result item as it leaves the block
    typedef struct packed {
        logic                 cell_write;
        logic [ADDR_W-1:0]    cell_address;
        logic [DATA_W-1:0]    cell_data;
        logic                 scroll_up;
        logic [ROW_OUT_W-1:0] cursor_row_out;
        logic [COL_OUT_W-1:0] cursor_col_out;
        logic [CNT_W-1:0]     chars_done;
    } t_console_result;

    // Console model plus the queue of results still owed by the block.
    // note_char() runs on every accepted character, check_result() on every
    // accepted result; a non-empty return string describes a mismatch.
    class console_scoreboard;
        int                   cur_row;
        int                   cur_col;
        logic [CNT_W-1:0]     req_count;
        logic [ATTR_W-1:0]    attribute;
        t_console_result      expected_q[$];

        function new();
            cur_row   = 0;
            cur_col   = 0;
            req_count = '0;
            attribute = ATTR_RESET;
        endfunction

        // Step down one row; at the bottom the cursor stays put and a scroll
        // is requested instead.
        function logic step_row();
            cur_row++;
            if (cur_row >= SCREEN_ROWS_DEF) begin
                cur_row = SCREEN_ROWS_DEF - 1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_char(logic [CHAR_W-1:0] ch, logic last);
            t_console_result r;
            r = '0;
            if (ch == CH_CR) begin
                cur_col = 0;
            end else if (ch == CH_LF) begin
                cur_col = 0;
                r.scroll_up = step_row();
            end else begin
                r.cell_write   = 1'b1;
                r.cell_address = ADDR_W'(cur_row * SCREEN_COLS_DEF + cur_col);
                r.cell_data    = {attribute, ch};
                cur_col++;
                if (cur_col >= SCREEN_COLS_DEF) begin
                    cur_col = 0;
                    r.scroll_up = step_row();
                end
            end
            if (req_count < COUNT_TOP)
                req_count++;
            r.cursor_row_out = ROW_OUT_W'(cur_row);
            r.cursor_col_out = COL_OUT_W'(cur_col);
            r.chars_done     = req_count;
            expected_q.push_back(r);
            // end of request: the count restarts for the next character
            if (last)
                req_count = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function string check_result(t_console_result got);
            t_console_result exp_r;
            string msg;
            msg = "";
            if (expected_q.size() == 0)
                return "result with nothing expected";
            exp_r = expected_q.pop_front();
            if (got.cell_write !== exp_r.cell_write)
                msg = {msg, $sformatf(" cell_write %0d/%0d", got.cell_write,
                                      exp_r.cell_write)};
            if (got.cell_address !== exp_r.cell_address)
                msg = {msg, $sformatf(" cell_address %0d/%0d", got.cell_address,
                                      exp_r.cell_address)};
            if (got.cell_data !== exp_r.cell_data)
                msg = {msg, $sformatf(" cell_data %h/%h", got.cell_data,
                                      exp_r.cell_data)};
            if (got.scroll_up !== exp_r.scroll_up)
                msg = {msg, $sformatf(" scroll_up %0d/%0d", got.scroll_up,
                                      exp_r.scroll_up)};
            if (got.cursor_row_out !== exp_r.cursor_row_out)
                msg = {msg, $sformatf(" row %0d/%0d", got.cursor_row_out,
                                      exp_r.cursor_row_out)};
            if (got.cursor_col_out !== exp_r.cursor_col_out)
                msg = {msg, $sformatf(" col %0d/%0d", got.cursor_col_out,
                                      exp_r.cursor_col_out)};
            if (got.chars_done !== exp_r.chars_done)
                msg = {msg, $sformatf(" chars_done %0d/%0d", got.chars_done,
                                      exp_r.chars_done)};
            if (msg != "")
                msg = {"got/expected:", msg};
            return msg;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ------------------------------------------------------------------
    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [ATTR_W-1:0] i_cfg_wdata;

    tcw_in_if  in_ch ();
    tcw_out_if res_ch ();

    text_console_writer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch.sink),
        .o_res       (res_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    console_scoreboard sb;

    int send_idle_pct  = 0;   // chance in 100 that the sender idles instead of sending
    int recv_stall_pct = 0;   // chance in 100 that the receiver stalls
    int mismatches     = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int writes_seen    = 0;
    int scrolls_seen   = 0;
    int max_count_seen = 0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // Receiver: ready is redrawn every cycle from the current stall rate.
    // During reset it stays low.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: all sampling happens at the rising edge on pre-edge values,
    // the same values the DUT sees. Results are checked before the new
    // character is noted; a result trails its item through the queue and the
    // result register, so the order is harmless, but it keeps the queue honest.
    always @(posedge i_clk) begin : monitor
        t_console_result got;
        string           msg;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got.cell_write     = res_ch.cell_write;
                got.cell_address   = res_ch.cell_address;
                got.cell_data      = res_ch.cell_data;
                got.scroll_up      = res_ch.scroll_up;
                got.cursor_row_out = res_ch.cursor_row_out;
                got.cursor_col_out = res_ch.cursor_col_out;
                got.chars_done     = res_ch.chars_done;
                msg = sb.check_result(got);
                if (msg != "")
                    report_mismatch(msg);
                results_seen++;
                if (got.cell_write)
                    writes_seen++;
                if (got.scroll_up)
                    scrolls_seen++;
                if (int'(got.chars_done) > max_count_seen)
                    max_count_seen = int'(got.chars_done);
            end
            // the attribute register takes the write at this same edge
            if (i_cfg_we)
                sb.attribute = i_cfg_wdata;
            if (in_ch.valid && in_ch.ready)
                sb.note_char(in_ch.char_byte, in_ch.last_char);
        end
    end

    // ------------------------------------------------------------------
    // Drive tasks. Each is entered just after a rising edge and returns just
    // after the edge that accepted its item, with valid still high, so the
    // next call can present new data without a bubble.
    // ------------------------------------------------------------------
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.char_byte <= ch;
        in_ch.last_char <= last;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // Stop sending, wait for every owed result, then let the pipeline settle
    // (a result leaves after its item has passed the queue and result register).
    task automatic drain_results();
        int n;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        n = 0;
        while (sb.pending() != 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Attribute writes only ever happen with the block idle.
    task automatic write_attr(input logic [ATTR_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [CHAR_W-1:0] rand_printable();
        logic [CHAR_W-1:0] b;
        do begin
            b = CHAR_W'($urandom_range(0, 255));
        end while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    // Random text in bursts: ordinary lines with some CR/LF, long runs that
    // wrap past the last column, and short control-heavy noise. A burst's last
    // character ends a request half the time, any other one 3 times in 100.
    task automatic run_traffic(input int n_items, input bit pause_mid);
        int                sent;
        int                len;
        int                kind;
        int                r;
        bit                paused;
        logic [CHAR_W-1:0] ch;
        logic              last;
        sent   = 0;
        paused = 0;
        while (sent < n_items) begin
            if (pause_mid && !paused && sent >= n_items / 2) begin
                // sender holds off until the block has caught up completely
                drain_results();
                paused = 1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 65)
                len = $urandom_range(5, 60);
            else if (kind < 85)
                len = $urandom_range(80, 170);
            else
                len = $urandom_range(1, 10);
            for (int k = 0; k < len; k++) begin
                r = $urandom_range(0, 99);
                if (kind < 65)
                    ch = (r < 6) ? CH_CR : (r < 14) ? CH_LF : rand_printable();
                else if (kind < 85)
                    ch = rand_printable();
                else
                    ch = (r < 40) ? CH_CR : (r < 80) ? CH_LF
                                  : CHAR_W'($urandom_range(0, 255));
                if (k == len - 1)
                    last = 1'($urandom_range(0, 1));
                else
                    last = ($urandom_range(0, 99) < 3);
                send_char(ch, last);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        sb = new();
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.char_byte <= '0;
        in_ch.last_char <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset attribute, byte extremes, CR at column 0, LF,
        // request end and count restart, bytes next to the control codes.
        send_char(8'h41, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(CH_CR, 1'b0);
        send_char(CH_CR, 1'b0);
        send_char(CH_LF, 1'b0);
        send_char(8'h7E, 1'b1);
        send_char(8'h42, 1'b0);
        send_char(CH_LF, 1'b1);
        send_char(CH_CR, 1'b1);
        send_char(8'h09, 1'b0);
        send_char(8'h0B, 1'b0);
        send_char(8'h0C, 1'b0);
        send_char(8'h0E, 1'b1);
        write_attr(8'hFF);
        send_char(8'h80, 1'b0);
        send_char(8'h01, 1'b1);
        write_attr(8'h00);
        send_char(8'h55, 1'b0);
        send_char(8'hAA, 1'b1);

        // One long request at full speed, printable bytes with occasional LFs;
        // the item after it checks the restart.
        write_attr(8'($urandom_range(1, 254)));
        for (int k = 0; k < 120; k++)
            send_char(($urandom_range(0, 99) < 5) ? CH_LF : rand_printable(),
                      (k == 119));
        send_char(rand_printable(), 1'b0);

        // Random phases with different idle patterns and attributes
        write_attr(8'($urandom_range(1, 254)));
        send_idle_pct = 0;  recv_stall_pct = 0;
        run_traffic(250, 1'b1);

        write_attr(8'hFF);
        send_idle_pct = 50; recv_stall_pct = 0;
        run_traffic(250, 1'b0);

        write_attr(8'($urandom_range(0, 255)));
        send_idle_pct = 0;  recv_stall_pct = 50;
        run_traffic(250, 1'b0);

        write_attr(ATTR_RESET);
        send_idle_pct = 18; recv_stall_pct = 18;
        run_traffic(250, 1'b0);

        // Wind down: everything owed must have arrived
        drain_results();
        if (sb.pending() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      sb.pending()));

        $display("covered %0d items, %0d results: %0d cell writes, %0d scrolls, peak count %0d",
                 items_sent, results_seen, writes_seen, scrolls_seen, max_count_seen);
        $display("idle patterns none / sender 50%% / receiver 50%% / both 18%%, attributes 00 FF 0C and random");
        if (mismatches == 0)
            $display("tb_text_console_writer: PASS");
        else
            $display("tb_text_console_writer: FAIL");
        $finish;
    end

    // Watchdog: the slowest correct run stays well under 100 us of simulated time
    initial begin
        #1_000_000;
        $display("tb_text_console_writer: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
design/tcw_pkg.sv
design/tcw_in_if.sv
design/tcw_out_if.sv
design/tcw_front.sv
design/tcw_back.sv
design/text_console_writer.sv
tb/sv/tb_text_console_writer.sv
